### sv/bcrop_pkg.sv
// ----------------------------------------------------------------------------
// bcrop_pkg
// Shared constants, register indexes and controller/datapath signal groups.
// ----------------------------------------------------------------------------
package bcrop_pkg;

    localparam int DEF_MAX_ROWS   = 1024;
    localparam int DEF_MAX_COLS   = 1024;
    localparam int DEF_PIXEL_BITS = 16;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int COUNT_W   = 11;
    localparam int MINVAR_W  = 16;
    localparam int MARGIN_W  = 10;
    localparam int FIELD_W   = 11;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MINVAR = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN = 2'd3;

    localparam logic [COUNT_W-1:0]  RST_ROWS   = 11'd1024;
    localparam logic [COUNT_W-1:0]  RST_COLS   = 11'd1024;
    localparam logic [MINVAR_W-1:0] RST_MINVAR = 16'd0;
    localparam logic [MARGIN_W-1:0] RST_MARGIN = 10'd0;

    typedef struct packed {
        logic accept_en;
        logic scan_start;
        logic scan_rd;
        logic calc;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic last_pixel;
        logic scan_last;
        logic out_free;
    } t_sts;

endpackage

### sv/bcrop_pix_if.sv
// ----------------------------------------------------------------------------
// bcrop_pix_if
// Pixel stream channel: valid/ready handshake with one gray value.
// ----------------------------------------------------------------------------
interface bcrop_pix_if #(
    parameter int PIXEL_BITS = bcrop_pkg::DEF_PIXEL_BITS
);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

### sv/bcrop_res_if.sv
// ----------------------------------------------------------------------------
// bcrop_res_if
// Crop result channel: valid/ready handshake with the four bounds and a flag.
// ----------------------------------------------------------------------------
interface bcrop_res_if;
    logic                                valid;
    logic                                ready;
    logic        [bcrop_pkg::FIELD_W-1:0] top_row;
    logic signed [bcrop_pkg::FIELD_W-1:0] bottom_row;
    logic        [bcrop_pkg::FIELD_W-1:0] left_col;
    logic signed [bcrop_pkg::FIELD_W-1:0] right_col;
    logic                                empty_res;

    modport source (output valid, output top_row, output bottom_row, output left_col,
                    output right_col, output empty_res, input ready);
    modport sink   (input valid, input top_row, input bottom_row, input left_col,
                    input right_col, input empty_res, output ready);
endinterface

### sv/bcrop_ram.sv
// ----------------------------------------------------------------------------
// bcrop_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bcrop_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### sv/bcrop_ctrl.sv
// ----------------------------------------------------------------------------
// bcrop_ctrl
// Frame sequencer: pixel stream, write drain, column scan, bound math, result.
// ----------------------------------------------------------------------------
module bcrop_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_pix_valid,
    input  bcrop_pkg::t_sts i_sts,
    output bcrop_pkg::t_cmd o_cmd
);
    import bcrop_pkg::*;

    typedef enum logic [5:0] {
        S_STREAM = 6'b000001,
        S_DRAIN  = 6'b000010,
        S_SCAN   = 6'b000100,
        S_TAIL   = 6'b001000,
        S_CALC   = 6'b010000,
        S_LOAD   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_STREAM: begin
                o_cmd.accept_en = 1'b1;
                if (i_pix_valid && i_sts.last_pixel) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                o_cmd.scan_start = 1'b1;
                n_state          = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                n_state = S_CALC;
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_LOAD;
            end
            S_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_STREAM;
                end
            end
            default: begin
                n_state = S_STREAM;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_STREAM;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

### sv/bcrop_dp.sv
// ----------------------------------------------------------------------------
// bcrop_dp
// Datapath: config registers, row range, column range memory, scan and bounds.
// ----------------------------------------------------------------------------
module bcrop_dp #(
    parameter int MAX_ROWS   = bcrop_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS   = bcrop_pkg::DEF_MAX_COLS,
    parameter int PIXEL_BITS = bcrop_pkg::DEF_PIXEL_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic        [bcrop_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic        [bcrop_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                                i_pix_valid,
    input  logic        [PIXEL_BITS-1:0]           i_pixel,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic        [bcrop_pkg::FIELD_W-1:0]   o_top_row,
    output logic signed [bcrop_pkg::FIELD_W-1:0]   o_bottom_row,
    output logic        [bcrop_pkg::FIELD_W-1:0]   o_left_col,
    output logic signed [bcrop_pkg::FIELD_W-1:0]   o_right_col,
    output logic                                o_empty_res,
    input  bcrop_pkg::t_cmd                     i_cmd,
    output bcrop_pkg::t_sts                     o_sts
);
    import bcrop_pkg::*;

    localparam int RPW   = $clog2(MAX_ROWS);
    localparam int CPW   = $clog2(MAX_COLS);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam int DW    = (PIXEL_BITS > MINVAR_W) ? PIXEL_BITS : MINVAR_W;
    localparam int MAXRC = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int SW    = $clog2(MAXRC + (1 << MARGIN_W)) + 2;
    localparam logic signed [SW-1:0] NEG_ONE = '1;

    // configuration
    logic [COUNT_W-1:0]  r_rows;
    logic [COUNT_W-1:0]  r_cols;
    logic [MINVAR_W-1:0] r_min_var;
    logic [MARGIN_W-1:0] r_margin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows    <= RST_ROWS;
            r_cols    <= RST_COLS;
            r_min_var <= RST_MINVAR;
            r_margin  <= RST_MARGIN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ROWS:   r_rows    <= i_cfg_data[COUNT_W-1:0];
                REG_COLS:   r_cols    <= i_cfg_data[COUNT_W-1:0];
                REG_MINVAR: r_min_var <= i_cfg_data[MINVAR_W-1:0];
                REG_MARGIN: r_margin  <= i_cfg_data[MARGIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    logic [RW-1:0] rows_c;
    logic [CW-1:0] cols_c;

    always_comb begin
        if (r_rows == '0) begin
            rows_c = RW'(1);
        end else if (32'(r_rows) > MAX_ROWS) begin
            rows_c = RW'(MAX_ROWS);
        end else begin
            rows_c = RW'(r_rows);
        end
        if (r_cols == '0) begin
            cols_c = CW'(1);
        end else if (32'(r_cols) > MAX_COLS) begin
            cols_c = CW'(MAX_COLS);
        end else begin
            cols_c = CW'(r_cols);
        end
    end

    // row range tracking
    logic [CPW-1:0]        r_col_pos;
    logic [RPW-1:0]        r_row_pos;
    logic [PIXEL_BITS-1:0] r_row_low;
    logic [PIXEL_BITS-1:0] r_row_high;
    logic [RPW-1:0]        r_first_row;
    logic [RPW-1:0]        r_last_row;
    logic                  r_row_found;

    logic                  acc;
    logic [PIXEL_BITS-1:0] n_row_low;
    logic [PIXEL_BITS-1:0] n_row_high;
    logic                  row_ok;
    logic                  end_row;
    logic                  row_last;

    assign acc = i_cmd.accept_en && i_pix_valid;

    always_comb begin
        if (r_col_pos == '0) begin
            n_row_low  = i_pixel;
            n_row_high = i_pixel;
        end else begin
            n_row_low  = (i_pixel < r_row_low)  ? i_pixel : r_row_low;
            n_row_high = (i_pixel > r_row_high) ? i_pixel : r_row_high;
        end
    end

    assign row_ok   = (n_row_high >= n_row_low) &&
                      (DW'(n_row_high - n_row_low) >= DW'(r_min_var));
    assign end_row  = ((CPW+1)'(r_col_pos) + 1'b1) >= (CPW+1)'(cols_c);
    assign row_last = ((RPW+1)'(r_row_pos) + 1'b1) >= (RPW+1)'(rows_c);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_pos   <= '0;
            r_row_pos   <= '0;
            r_row_found <= 1'b0;
        end else begin
            if (acc) begin
                if (end_row) begin
                    r_col_pos <= '0;
                    if (row_ok) begin
                        r_row_found <= 1'b1;
                    end
                    r_row_pos <= row_last ? '0 : r_row_pos + 1'b1;
                end else begin
                    r_col_pos <= r_col_pos + 1'b1;
                end
            end
            if (i_cmd.calc) begin
                r_row_found <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_row_low  <= n_row_low;
            r_row_high <= n_row_high;
            if (end_row && row_ok) begin
                if (!r_row_found) begin
                    r_first_row <= r_row_pos;
                end
                r_last_row <= r_row_pos;
            end
        end
    end

    // column range memory: read at accept, update in the next cycle
    logic                  r_s1_vld;
    logic [PIXEL_BITS-1:0] r_s1_pix;
    logic [CPW-1:0]        r_s1_col;
    logic                  r_s1_first;
    logic                  r_fw_vld;
    logic [CPW-1:0]        r_fw_addr;
    logic [PIXEL_BITS-1:0] r_fw_low;
    logic [PIXEL_BITS-1:0] r_fw_high;

    logic [2*PIXEL_BITS-1:0] rd_data;
    logic [PIXEL_BITS-1:0]   rd_low;
    logic [PIXEL_BITS-1:0]   rd_high;
    logic [PIXEL_BITS-1:0]   base_low;
    logic [PIXEL_BITS-1:0]   base_high;
    logic [PIXEL_BITS-1:0]   upd_low;
    logic [PIXEL_BITS-1:0]   upd_high;
    logic                    fw_hit;
    logic [CPW-1:0]          r_k;
    logic [CPW-1:0]          raddr;

    assign rd_low    = rd_data[PIXEL_BITS-1:0];
    assign rd_high   = rd_data[2*PIXEL_BITS-1:PIXEL_BITS];
    assign fw_hit    = r_fw_vld && (r_fw_addr == r_s1_col);
    assign base_low  = fw_hit ? r_fw_low  : rd_low;
    assign base_high = fw_hit ? r_fw_high : rd_high;

    always_comb begin
        if (r_s1_first) begin
            upd_low  = r_s1_pix;
            upd_high = r_s1_pix;
        end else begin
            upd_low  = (r_s1_pix < base_low)  ? r_s1_pix : base_low;
            upd_high = (r_s1_pix > base_high) ? r_s1_pix : base_high;
        end
    end

    assign raddr = i_cmd.scan_rd ? r_k : r_col_pos;

    bcrop_ram #(
        .WIDTH (2 * PIXEL_BITS),
        .DEPTH (MAX_COLS)
    ) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_vld),
        .i_waddr (r_s1_col),
        .i_wdata ({upd_high, upd_low}),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_fw_vld <= 1'b0;
        end else begin
            r_s1_vld <= acc;
            r_fw_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_pix   <= i_pixel;
        r_s1_col   <= r_col_pos;
        r_s1_first <= (r_row_pos == '0);
        r_fw_addr  <= r_s1_col;
        r_fw_low   <= upd_low;
        r_fw_high  <= upd_high;
    end

    // column scan
    logic           r_sv;
    logic [CPW-1:0] r_sk;
    logic           r_col_found;
    logic [CPW-1:0] r_first_col;
    logic [CPW-1:0] r_last_col;
    logic           col_ok;

    assign col_ok = (rd_high >= rd_low) && (DW'(rd_high - rd_low) >= DW'(r_min_var));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv        <= 1'b0;
            r_k         <= '0;
            r_col_found <= 1'b0;
        end else begin
            r_sv <= i_cmd.scan_rd;
            if (i_cmd.scan_start) begin
                r_k         <= '0;
                r_col_found <= 1'b0;
            end else if (i_cmd.scan_rd) begin
                r_k <= r_k + 1'b1;
            end
            if (r_sv && col_ok) begin
                r_col_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sk <= r_k;
        if (r_sv && col_ok) begin
            if (!r_col_found) begin
                r_first_col <= r_sk;
            end
            r_last_col <= r_sk;
        end
    end

    // bound math
    logic signed [SW-1:0] rows_s;
    logic signed [SW-1:0] cols_s;
    logic signed [SW-1:0] mar_s;
    logic signed [SW-1:0] top_m;
    logic signed [SW-1:0] bot_m;
    logic signed [SW-1:0] lft_m;
    logic signed [SW-1:0] rgt_m;
    logic signed [SW-1:0] top_c;
    logic signed [SW-1:0] bot_c;
    logic signed [SW-1:0] lft_c;
    logic signed [SW-1:0] rgt_c;
    logic signed [SW-1:0] r_top;
    logic signed [SW-1:0] r_bot;
    logic signed [SW-1:0] r_lft;
    logic signed [SW-1:0] r_rgt;

    assign rows_s = SW'(rows_c);
    assign cols_s = SW'(cols_c);
    assign mar_s  = SW'(r_margin);

    always_comb begin
        top_m = (r_row_found ? SW'(r_first_row) : rows_s) + mar_s;
        bot_m = (r_row_found ? SW'(r_last_row) : NEG_ONE) - mar_s;
        lft_m = (r_col_found ? SW'(r_first_col) : cols_s) + mar_s;
        rgt_m = (r_col_found ? SW'(r_last_col) : NEG_ONE) - mar_s;

        top_c = (top_m > rows_s) ? rows_s : top_m;
        lft_c = (lft_m > cols_s) ? cols_s : lft_m;
        if (bot_m < NEG_ONE) begin
            bot_c = NEG_ONE;
        end else if (bot_m > rows_s + NEG_ONE) begin
            bot_c = rows_s + NEG_ONE;
        end else begin
            bot_c = bot_m;
        end
        if (rgt_m < NEG_ONE) begin
            rgt_c = NEG_ONE;
        end else if (rgt_m > cols_s + NEG_ONE) begin
            rgt_c = cols_s + NEG_ONE;
        end else begin
            rgt_c = rgt_m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_top <= top_c;
            r_bot <= bot_c;
            r_lft <= lft_c;
            r_rgt <= rgt_c;
        end
    end

    // result register
    logic                       r_out_vld;
    logic        [FIELD_W-1:0]  r_out_top;
    logic signed [FIELD_W-1:0]  r_out_bot;
    logic        [FIELD_W-1:0]  r_out_lft;
    logic signed [FIELD_W-1:0]  r_out_rgt;
    logic                       r_out_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_top   <= FIELD_W'(r_top);
            r_out_bot   <= FIELD_W'(r_bot);
            r_out_lft   <= FIELD_W'(r_lft);
            r_out_rgt   <= FIELD_W'(r_rgt);
            r_out_empty <= (r_top > r_bot) || (r_lft > r_rgt);
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_top_row    = r_out_top;
    assign o_bottom_row = r_out_bot;
    assign o_left_col   = r_out_lft;
    assign o_right_col  = r_out_rgt;
    assign o_empty_res  = r_out_empty;

    assign o_sts.last_pixel = end_row && row_last;
    assign o_sts.scan_last  = ((CPW+1)'(r_k) + 1'b1) >= (CPW+1)'(cols_c);
    assign o_sts.out_free   = !r_out_vld || i_out_ready;
endmodule

### sv/border_crop_by_line_range.sv
// ----------------------------------------------------------------------------
// border_crop_by_line_range
// Finds the content rectangle of a frame from per-row and per-column ranges.
// ----------------------------------------------------------------------------
// Usage:
//   i_pix takes one pixel per transfer in raster order, one per cycle while a
//   frame streams. Rows and columns whose max minus min reaches min_variation
//   count as content. Registers are written over i_cfg_we/i_cfg_idx/i_cfg_data;
//   the user must do so only while the block is idle; the block does not check.
//   Each pixel updates the row range at once and the column range memory
//   (read at transfer, write the next cycle, last write forwarded).
//   After the last pixel of a frame i_pix.ready drops through a drain state,
//   a column scan of one memory read per column, a state for the last scan
//   data, one for margin and clamping, and one to load the result, which
//   waits for o_res to be free. i_pix.ready returns once the result is loaded.
//   o_res holds its result until taken; the next frame streams meanwhile and
//   only its result load waits for o_res to be free.
//   Reset sets the registers to their defaults and empties the pipeline and
//   the result register; the column memory needs no clearing since row 0 of
//   every frame overwrites each column entry.
// ----------------------------------------------------------------------------
module border_crop_by_line_range #(
    parameter int MAX_ROWS   = bcrop_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS   = bcrop_pkg::DEF_MAX_COLS,
    parameter int PIXEL_BITS = bcrop_pkg::DEF_PIXEL_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bcrop_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bcrop_pkg::CFG_W-1:0]     i_cfg_data,
    bcrop_pix_if.sink                       i_pix,
    bcrop_res_if.source                     o_res
);
    import bcrop_pkg::*;

    t_cmd cmd;
    t_sts sts;

    bcrop_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (i_pix.valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bcrop_dp #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_pix_valid  (i_pix.valid),
        .i_pixel      (i_pix.pixel),
        .i_out_ready  (o_res.ready),
        .o_out_valid  (o_res.valid),
        .o_top_row    (o_res.top_row),
        .o_bottom_row (o_res.bottom_row),
        .o_left_col   (o_res.left_col),
        .o_right_col  (o_res.right_col),
        .o_empty_res  (o_res.empty_res),
        .i_cmd        (cmd),
        .o_sts        (sts)
    );

    assign i_pix.ready = cmd.accept_en;
endmodule

### sv/bcrop_chk.sv
// ----------------------------------------------------------------------------
// bcrop_chk
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module bcrop_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                i_ready,
    input logic        [bcrop_pkg::FIELD_W-1:0] i_top_row,
    input logic signed [bcrop_pkg::FIELD_W-1:0] i_bottom_row,
    input logic        [bcrop_pkg::FIELD_W-1:0] i_left_col,
    input logic signed [bcrop_pkg::FIELD_W-1:0] i_right_col,
    input logic                                i_empty_res
);
    import bcrop_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result valid right after reset");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable(i_top_row) && $stable(i_bottom_row) &&
            $stable(i_left_col) && $stable(i_right_col) && $stable(i_empty_res))
        else $error("result changed while stalled");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_empty_res ==
            (($signed({1'b0, i_top_row}) > $signed({i_bottom_row[FIELD_W-1], i_bottom_row})) ||
             ($signed({1'b0, i_left_col}) > $signed({i_right_col[FIELD_W-1], i_right_col}))))
        else $error("empty flag disagrees with bounds");
endmodule

bind border_crop_by_line_range bcrop_chk u_bcrop_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_res.valid),
    .i_ready      (o_res.ready),
    .i_top_row    (o_res.top_row),
    .i_bottom_row (o_res.bottom_row),
    .i_left_col   (o_res.left_col),
    .i_right_col  (o_res.right_col),
    .i_empty_res  (o_res.empty_res)
);

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Streams frames of pixels into border_crop_by_line_range under several
// register settings and random stalls on both channels. An untimed
// model of the row and column range tracking predicts each crop result,
// and every result transfer is checked field by field against it.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bcrop_pkg::*;

    localparam int PIX_W         = DEF_PIXEL_BITS;
    localparam int RANDOM_PIXELS = 950;
    localparam int CYCLE_LIMIT   = 600_000;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        logic [FIELD_W-1:0] top;
        logic [FIELD_W-1:0] bottom;
        logic [FIELD_W-1:0] left;
        logic [FIELD_W-1:0] right;
        logic               empty;
    } t_crop_bounds;

    class t_crop_bounds_tracker;
        logic [COUNT_W-1:0]  rows_reg;
        logic [COUNT_W-1:0]  cols_reg;
        logic [MINVAR_W-1:0] minvar_reg;
        logic [MARGIN_W-1:0] margin_reg;
        t_pix                row_lo;
        t_pix                row_hi;
        t_pix                col_lo [DEF_MAX_COLS];
        t_pix                col_hi [DEF_MAX_COLS];
        int unsigned         row_idx;
        int unsigned         col_idx;
        int unsigned         first_row;
        int unsigned         last_row;
        bit                  row_hit;
        t_crop_bounds        expected_bounds [$];
        int unsigned         errors;

        function new();
            rows_reg   = RST_ROWS;
            cols_reg   = RST_COLS;
            minvar_reg = RST_MINVAR;
            margin_reg = RST_MARGIN;
            foreach (col_lo[k]) begin
                col_lo[k] = '0;
                col_hi[k] = '0;
            end
            errors = 0;
            restart();
        endfunction

        function void restart();
            row_lo    = '1;
            row_hi    = '0;
            row_idx   = 0;
            col_idx   = 0;
            first_row = 0;
            last_row  = 0;
            row_hit   = 1'b0;
        endfunction

        function int unsigned clamp_count(logic [COUNT_W-1:0] v, int unsigned mx);
            if (v == 0) return 1;
            return (v > mx) ? mx : v;
        endfunction

        function int unsigned eff_rows();
            return clamp_count(rows_reg, DEF_MAX_ROWS);
        endfunction

        function int unsigned eff_cols();
            return clamp_count(cols_reg, DEF_MAX_COLS);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_ROWS:   rows_reg   = data[COUNT_W-1:0];
                REG_COLS:   cols_reg   = data[COUNT_W-1:0];
                REG_MINVAR: minvar_reg = data[MINVAR_W-1:0];
                REG_MARGIN: margin_reg = data[MARGIN_W-1:0];
                default: ;
            endcase
        endfunction

        function bit wide_enough(t_pix hi, t_pix lo);
            return (hi >= lo) && ((int'(hi) - int'(lo)) >= int'(minvar_reg));
        endfunction

        function void note_pixel(t_pix p);
            int unsigned  rows_n;
            int unsigned  cols_n;
            int           top;
            int           bot;
            int           lft;
            int           rgt;
            bit           col_hit;
            t_crop_bounds b;
            rows_n = eff_rows();
            cols_n = eff_cols();
            if (col_idx == 0) begin
                row_lo = p;
                row_hi = p;
            end else begin
                if (p < row_lo) row_lo = p;
                if (p > row_hi) row_hi = p;
            end
            if (row_idx == 0) begin
                col_lo[col_idx] = p;
                col_hi[col_idx] = p;
            end else begin
                if (p < col_lo[col_idx]) col_lo[col_idx] = p;
                if (p > col_hi[col_idx]) col_hi[col_idx] = p;
            end
            if (col_idx + 1 < cols_n) begin
                col_idx++;
                return;
            end
            if (wide_enough(row_hi, row_lo)) begin
                if (!row_hit) first_row = row_idx;
                last_row = row_idx;
                row_hit  = 1'b1;
            end
            col_idx = 0;
            if (row_idx + 1 < rows_n) begin
                row_idx++;
                return;
            end
            top     = row_hit ? int'(first_row) : int'(rows_n);
            bot     = row_hit ? int'(last_row) : -1;
            lft     = int'(cols_n);
            rgt     = -1;
            col_hit = 1'b0;
            for (int k = 0; k < int'(cols_n); k++) begin
                if (wide_enough(col_hi[k], col_lo[k])) begin
                    if (!col_hit) lft = k;
                    rgt     = k;
                    col_hit = 1'b1;
                end
            end
            top += int'(margin_reg);
            bot -= int'(margin_reg);
            lft += int'(margin_reg);
            rgt -= int'(margin_reg);
            if (top > int'(rows_n)) top = int'(rows_n);
            if (bot < -1) bot = -1;
            if (bot > int'(rows_n) - 1) bot = int'(rows_n) - 1;
            if (lft > int'(cols_n)) lft = int'(cols_n);
            if (rgt < -1) rgt = -1;
            if (rgt > int'(cols_n) - 1) rgt = int'(cols_n) - 1;
            b.top    = top[FIELD_W-1:0];
            b.bottom = bot[FIELD_W-1:0];
            b.left   = lft[FIELD_W-1:0];
            b.right  = rgt[FIELD_W-1:0];
            b.empty  = (top > bot) || (lft > rgt);
            expected_bounds = {expected_bounds, b};
            restart();
        endfunction

        function void check_field(string fld, logic [FIELD_W-1:0] exp_v,
                                  logic [FIELD_W-1:0] got_v, bit sgn);
            if (got_v !== exp_v) begin
                errors++;
                if (sgn)
                    $display("%0t: %s expected %0d actual %0d", $time, fld,
                             $signed(exp_v), $signed(got_v));
                else
                    $display("%0t: %s expected %0d actual %0d", $time, fld, exp_v, got_v);
            end
        endfunction

        function void check_bounds(t_crop_bounds got);
            t_crop_bounds exp_b;
            if (expected_bounds.size() == 0) begin
                errors++;
                $display("%0t: crop result with none expected: top %0d bottom %0d left %0d right %0d empty %0b",
                         $time, got.top, $signed(got.bottom), got.left, $signed(got.right),
                         got.empty);
                return;
            end
            exp_b = expected_bounds.pop_front();
            check_field("top_row",    exp_b.top,    got.top,    1'b0);
            check_field("bottom_row", exp_b.bottom, got.bottom, 1'b1);
            check_field("left_col",   exp_b.left,   got.left,   1'b0);
            check_field("right_col",  exp_b.right,  got.right,  1'b1);
            check_field("empty_res",  exp_b.empty,  got.empty,  1'b0);
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    bcrop_pix_if #(.PIXEL_BITS(PIX_W)) pix_if ();
    bcrop_res_if                       res_if ();

    t_crop_bounds_tracker sb;
    int unsigned          src_idle_pct;
    int unsigned          snk_idle_pct;
    int unsigned          pixels_sent = 0;
    int unsigned          cycles = 0;

    border_crop_by_line_range u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pix      (pix_if),
        .o_res      (res_if)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge i_clk) begin
        t_crop_bounds got;
        if (i_rst_n) begin
            if (pix_if.valid && pix_if.ready) sb.note_pixel(pix_if.pixel);
            if (res_if.valid && res_if.ready) begin
                got.top    = res_if.top_row;
                got.bottom = res_if.bottom_row;
                got.left   = res_if.left_col;
                got.right  = res_if.right_col;
                got.empty  = res_if.empty_res;
                sb.check_bounds(got);
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    task automatic set_config(int unsigned rows_v, int unsigned cols_v,
                              int unsigned minvar_v, int unsigned margin_v);
        write_reg(REG_ROWS,   CFG_W'(rows_v));
        write_reg(REG_COLS,   CFG_W'(cols_v));
        write_reg(REG_MINVAR, CFG_W'(minvar_v));
        write_reg(REG_MARGIN, CFG_W'(margin_v));
    endtask

    task automatic send_pixel(t_pix p);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            pix_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.pixel <= p;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        pixels_sent++;
    endtask

    task automatic send_pixels(t_pix q [$]);
        foreach (q[k]) send_pixel(q[k]);
    endtask

    task automatic send_frame();
        int unsigned nr;
        int unsigned nc;
        int unsigned style;
        int unsigned r0;
        int unsigned r1;
        int unsigned c0;
        int unsigned c1;
        bit          in_rect;
        t_pix        base;
        t_pix        p;
        nr    = sb.eff_rows();
        nc    = sb.eff_cols();
        style = $urandom_range(3);
        base  = t_pix'($urandom_range(0, 65532));
        r0    = $urandom_range(0, nr - 1);
        r1    = $urandom_range(r0, nr - 1);
        c0    = $urandom_range(0, nc - 1);
        c1    = $urandom_range(c0, nc - 1);
        for (int unsigned r = 0; r < nr; r++) begin
            for (int unsigned c = 0; c < nc; c++) begin
                in_rect = (r >= r0) && (r <= r1) && (c >= c0) && (c <= c1);
                case (style)
                    0: p = t_pix'($urandom);
                    1: p = in_rect ? t_pix'($urandom) : base + t_pix'($urandom_range(0, 3));
                    2: p = base;
                    default: p = in_rect ? ($urandom_range(1) ? '1 : '0) : base;
                endcase
                send_pixel(p);
            end
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        pix_if.valid <= 1'b0;
        while (sb.expected_bounds.size() != 0) @(posedge i_clk);
        repeat (sb.eff_cols() + 8) @(posedge i_clk);
    endtask

    task automatic random_phase();
        int unsigned rows_v;
        int unsigned cols_v;
        int unsigned minvar_v;
        int unsigned margin_v;
        rows_v = $urandom_range(1, 6);
        cols_v = $urandom_range(1, 6);
        case ($urandom_range(7))
            0: rows_v = 0;
            1: cols_v = 0;
            2: begin
                rows_v = $urandom_range(7, 40);
                cols_v = $urandom_range(0, 2);
            end
            3: begin
                cols_v = $urandom_range(7, 40);
                rows_v = $urandom_range(0, 2);
            end
            default: ;
        endcase
        case ($urandom_range(4))
            0: minvar_v = 0;
            1: minvar_v = $urandom_range(1, 8);
            2: minvar_v = $urandom_range(0, 2000);
            3: minvar_v = $urandom_range(0, 65535);
            default: minvar_v = 65535;
        endcase
        case ($urandom_range(5))
            0: margin_v = $urandom_range(0, 1023);
            1: margin_v = 1023;
            default: margin_v = $urandom_range(0, 2);
        endcase
        set_config(rows_v, cols_v, minvar_v, margin_v);
        repeat ($urandom_range(1, 4)) send_frame();
        drain();
    endtask

    initial begin
        int unsigned stop_at;
        t_pix        frame_q [$];
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = REG_ROWS;
        cfg_data     = '0;
        pix_if.valid = 1'b0;
        pix_if.pixel = '0;
        res_if.ready = 1'b0;
        src_idle_pct = 17;
        snk_idle_pct = 82;
        sb           = new();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_config(0, 0, 0, 0);
        frame_q = '{16'h0000};
        send_pixels(frame_q);
        drain();

        set_config(2, 2, 16'hFFFF, 0);
        frame_q = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000,
                    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        send_pixels(frame_q);
        drain();

        set_config(2, 3, 1, 1023);
        frame_q = '{16'd5, 16'd5, 16'd5, 16'd5, 16'd9, 16'd5};
        send_pixels(frame_q);
        drain();

        set_config(3, 3, 100, 0);
        frame_q = '{16'd7, 16'd7, 16'd7, 16'd7, 16'd900, 16'd7, 16'd7, 16'd7, 16'd150};
        send_pixels(frame_q);
        drain();

        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    src_idle_pct = 17;
                    snk_idle_pct = 82;
                    set_config(1024, 0, 0, 1023);
                    send_frame();
                    drain();
                end
                1: begin
                    src_idle_pct = 82;
                    snk_idle_pct = 17;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                    set_config(0, 2047, 0, $urandom_range(0, 1023));
                    send_frame();
                    drain();
                end
            endcase
            stop_at = pixels_sent + RANDOM_PIXELS / 3;
            while (pixels_sent < stop_at) random_phase();
        end

        if (sb.errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule
